/* rtl/bita_pkg.sv */
// Shared types and constants of the bone influence top-4 accumulator.
package bita_pkg;

    // Sizing
    localparam int SLOT_COUNT  = 4;
    localparam int BONE_BITS   = 8;
    localparam int WEIGHT_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int SLOT_W_BITS = 20;
    localparam int SUM_BITS    = SLOT_W_BITS + $clog2(SLOT_COUNT);
    localparam int SHARE_BITS  = FRAC_BITS + 1;
    localparam int IDX_BITS    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [SLOT_W_BITS-1:0] SLOT_W_MAX = {SLOT_W_BITS{1'b1}};
    localparam logic [SHARE_BITS-1:0]  SHARE_ONE  = SHARE_BITS'(1) << FRAC_BITS;

    // Item modes
    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_NORM = 1'b1;

    // Input item
    typedef struct packed {
        logic                   mode;
        logic [BONE_BITS-1:0]   bone_index;
        logic [WEIGHT_BITS-1:0] weight;
    } t_in;

    // Result item
    typedef struct packed {
        logic [BONE_BITS-1:0]  bone_a;
        logic [BONE_BITS-1:0]  bone_b;
        logic [BONE_BITS-1:0]  bone_c;
        logic [BONE_BITS-1:0]  bone_d;
        logic [SHARE_BITS-1:0] share_a;
        logic [SHARE_BITS-1:0] share_b;
        logic [SHARE_BITS-1:0] share_c;
        logic [SHARE_BITS-1:0] share_d;
    } t_out;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/bita_divider.sv */
// Bit-serial restoring divider: floor((weight << FRAC_BITS) / total), one quotient bit a cycle.
module bita_divider import bita_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SLOT_W_BITS-1:0] i_dividend,
    input  logic [SUM_BITS-1:0]    i_divisor,
    output t_div_stat              o_stat,
    output logic [SHARE_BITS-1:0]  o_quotient
);

    localparam int CNT_BITS = $clog2(SHARE_BITS);

    // Dividend <= divisor, so the quotient fits SHARE_BITS and the remainder stays below divisor
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                  r_first, n_first;
    logic                  r_low, n_low;
    logic [SUM_BITS-1:0]   r_rem, n_rem;
    logic [SUM_BITS-1:0]   r_div, n_div;
    logic [SHARE_BITS-1:0] r_quo, n_quo;
    logic [SUM_BITS:0]     w_trial;
    logic                  w_fit;

    // One shift-compare-subtract step
    always_comb begin
        w_trial = {r_rem, (r_first ? r_low : 1'b0)};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_first = r_first;
        n_low   = r_low;
        n_rem   = r_rem;
        n_div   = r_div;
        n_quo   = r_quo;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_BITS'(SHARE_BITS - 1);
            n_first = 1'b1;
            n_low   = i_dividend[0];
            n_rem   = SUM_BITS'(i_dividend >> 1);
            n_div   = i_divisor;
            n_quo   = '0;
        end else if (r_busy) begin
            n_first = 1'b0;
            n_rem   = w_fit ? SUM_BITS'(w_trial - {1'b0, r_div}) : w_trial[SUM_BITS-1:0];
            n_quo   = {r_quo[SHARE_BITS-2:0], w_fit};
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_first <= n_first;
        r_low   <= n_low;
        r_rem   <= n_rem;
        r_div   <= n_div;
        r_quo   <= n_quo;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

/* rtl/bone_influence_top4_accumulator.sv */
// Top level: influence slots, add logic, normalize sequencer and result register.
//
// Keeps up to four bone influences of one vertex and emits them normalized.
// Input channel i_valid/o_ready carries t_in; output channel o_valid/i_ready
// carries t_out. A transfer happens when valid and ready are both high.
// An add item (mode 0) is applied in the cycle it is accepted, so adds go
// at one per cycle while the sequencer is idle, with no result. A normalize
// item (mode 1) sums the slots in its sum step, then runs the shared
// bit-serial divider once per slot, each run a load, one quotient bit per
// step and a handoff of the quotient into that slot's share register,
// before the emit step loads the result register.
// An all-zero vertex skips the divider and emits share 1.0 on slot a.
// o_ready is high only while the sequencer is idle. The block keeps taking
// add items while a result waits in the output register; a normalize that
// finishes while the receiver stalls holds in its emit step until the result
// register frees, and clears the slots when the result is loaded.
// Synchronous active-low reset clears all slots, the sequencer and o_valid.
module bone_influence_top4_accumulator import bita_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SUM  = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [BONE_BITS-1:0]   r_slot_bone   [SLOT_COUNT];
    logic [BONE_BITS-1:0]   n_slot_bone   [SLOT_COUNT];
    logic [SLOT_W_BITS-1:0] r_slot_weight [SLOT_COUNT];
    logic [SLOT_W_BITS-1:0] n_slot_weight [SLOT_COUNT];
    logic [SHARE_BITS-1:0]  r_share       [SLOT_COUNT];
    logic [SHARE_BITS-1:0]  n_share       [SLOT_COUNT];
    logic [SUM_BITS-1:0]    r_total, n_total;
    logic [IDX_BITS-1:0]    r_idx, n_idx;
    logic                   r_zero, n_zero;
    logic                   r_div_start, n_div_start;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic                   w_accept;
    logic [SUM_BITS-1:0]    w_sum;
    logic [SLOT_COUNT-1:0]  w_hit, w_empty;
    logic [IDX_BITS-1:0]    w_hit_idx, w_empty_idx, w_min_idx;
    logic [SLOT_W_BITS:0]   w_merge;
    logic [SLOT_W_BITS-1:0] w_new_w;
    t_div_stat              w_div;
    logic [SHARE_BITS-1:0]  w_quo;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);

    // Slot search for an add: same bone, first empty, smallest
    always_comb begin
        w_hit       = '0;
        w_empty     = '0;
        w_hit_idx   = '0;
        w_empty_idx = '0;
        w_min_idx   = '0;
        w_new_w     = SLOT_W_BITS'(i_data.weight);
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_empty[i] = (r_slot_weight[i] == '0);
            w_hit[i]   = !w_empty[i] && (r_slot_bone[i] == i_data.bone_index);
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (w_hit[i])   w_hit_idx   = IDX_BITS'(i);
            if (w_empty[i]) w_empty_idx = IDX_BITS'(i);
        end
        for (int i = 1; i < SLOT_COUNT; i++) begin
            if (r_slot_weight[i] < r_slot_weight[w_min_idx]) w_min_idx = IDX_BITS'(i);
        end
        w_merge = {1'b0, r_slot_weight[w_hit_idx]} + (SLOT_W_BITS + 1)'(i_data.weight);
    end

    // Slot total for normalize
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            w_sum = w_sum + SUM_BITS'(r_slot_weight[i]);
        end
    end

    // Sequencer and slot updates
    always_comb begin
        n_state     = r_state;
        n_slot_bone   = r_slot_bone;
        n_slot_weight = r_slot_weight;
        n_share     = r_share;
        n_total     = r_total;
        n_idx       = r_idx;
        n_zero      = r_zero;
        n_div_start = 1'b0;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_data.mode == MODE_NORM) begin
                    n_state = S_SUM;
                end else if (w_accept && i_data.weight != '0) begin
                    if (|w_hit) begin
                        n_slot_weight[w_hit_idx] = w_merge[SLOT_W_BITS] ? SLOT_W_MAX
                                                   : w_merge[SLOT_W_BITS-1:0];
                    end else if (|w_empty) begin
                        n_slot_bone[w_empty_idx]   = i_data.bone_index;
                        n_slot_weight[w_empty_idx] = w_new_w;
                    end else if (w_new_w > r_slot_weight[w_min_idx]) begin
                        n_slot_bone[w_min_idx]   = i_data.bone_index;
                        n_slot_weight[w_min_idx] = w_new_w;
                    end
                end
            end
            S_SUM: begin
                n_total = w_sum;
                n_idx   = '0;
                if (w_sum == '0) begin
                    n_zero  = 1'b1;
                    n_state = S_EMIT;
                    for (int i = 0; i < SLOT_COUNT; i++) n_share[i] = '0;
                    n_share[0] = SHARE_ONE;
                end else begin
                    n_zero      = 1'b0;
                    n_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_share[r_idx] = w_quo;
                    if (r_idx == IDX_BITS'(SLOT_COUNT - 1)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_idx       = r_idx + 1'b1;
                        n_div_start = 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid   = 1'b1;
                    n_out.bone_a  = r_zero ? '0 : r_slot_bone[0];
                    n_out.bone_b  = r_zero ? '0 : r_slot_bone[1];
                    n_out.bone_c  = r_zero ? '0 : r_slot_bone[2];
                    n_out.bone_d  = r_zero ? '0 : r_slot_bone[3];
                    n_out.share_a = r_share[0];
                    n_out.share_b = r_share[1];
                    n_out.share_c = r_share[2];
                    n_out.share_d = r_share[3];
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        n_slot_bone[i]   = '0;
                        n_slot_weight[i] = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_bone[i]   <= '0;
                r_slot_weight[i] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_div_start   <= n_div_start;
            r_out_valid   <= n_out_valid;
            r_slot_bone   <= n_slot_bone;
            r_slot_weight <= n_slot_weight;
        end
        r_share <= n_share;
        r_total <= n_total;
        r_idx   <= n_idx;
        r_zero  <= n_zero;
        r_out   <= n_out;
    end

    // Shared divider, one slot at a time
    bita_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_slot_weight[r_idx]),
        .i_divisor  (r_total),
        .o_stat     (w_div),
        .o_quotient (w_quo)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Checks
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_total != '0))
        else $error("divider running on a zero total");

    a_rose_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_EMIT))
        else $error("result appeared outside the emit step");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> !o_ready)
        else $error("input accepted while the divider runs");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

endmodule
